// ----- hdl/sbd_pkg.sv -----
// shared constants, payload types, state enum and arctangent table for the correlator
package sbd_pkg;

  localparam int unsigned MAX_SAMPLES  = 512;
  localparam int unsigned ANGLE_BITS   = 16;
  localparam int unsigned CORDIC_STEPS = 16;

  localparam int unsigned POS_W   = 24;
  localparam int unsigned FREQ_W  = 24;
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned SUM_W   = 26;
  localparam int unsigned CNT_W   = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned ACC_W   = 32;
  localparam int unsigned XY_W    = 34;
  localparam int unsigned STEP_W  = $clog2(CORDIC_STEPS);
  localparam int unsigned DIV_W   = SUM_W + 1;

  localparam logic signed [XY_W-1:0] GAIN_INV = XY_W'(39797);

  typedef struct packed {
    logic [POS_W-1:0]        sample_position;
    logic signed [VAL_W-1:0] sample_value;
    logic                    last_sample;
  } sbd_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] rotated_real;
    logic signed [VAL_W-1:0] rotated_imag;
    logic signed [VAL_W-1:0] weight_real;
    logic signed [VAL_W-1:0] weight_imag;
    logic                    weight_valid;
    logic                    count_overflow;
  } sbd_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ROT,
    ST_ACC,
    ST_DIV_START,
    ST_DIV,
    ST_OUT
  } sbd_state_e;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [31:0] atan_turns(input logic [STEP_W-1:0] i);
    logic [31:0] r;
    unique case (i)
      4'd0:    r = 32'd536870912;
      4'd1:    r = 32'd316933406;
      4'd2:    r = 32'd167458907;
      4'd3:    r = 32'd85004756;
      4'd4:    r = 32'd42667331;
      4'd5:    r = 32'd21354465;
      4'd6:    r = 32'd10679838;
      4'd7:    r = 32'd5340245;
      4'd8:    r = 32'd2670163;
      4'd9:    r = 32'd1335087;
      4'd10:   r = 32'd667544;
      4'd11:   r = 32'd333772;
      4'd12:   r = 32'd166886;
      4'd13:   r = 32'd83443;
      4'd14:   r = 32'd41722;
      4'd15:   r = 32'd20861;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/sbd_phase_mul.sv -----
// digit-serial position times frequency multiplier, rounds the product to a phase angle
module sbd_phase_mul (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [sbd_pkg::POS_W-1:0]       pos_i,
  input  logic [sbd_pkg::FREQ_W-1:0]      freq_i,
  output logic                            done_o,
  output logic [sbd_pkg::ANGLE_BITS-1:0]  phase_o
);
  import sbd_pkg::*;

  localparam int unsigned NDIG   = FREQ_W / DIGIT_W;
  localparam int unsigned DCNT_W = $clog2(NDIG);
  localparam logic [ACC_W-1:0] RND = ACC_W'(1) << (ACC_W - 1 - ANGLE_BITS);

  logic [ACC_W-1:0]  acc_q, mcand_q, part, rnd;
  logic [FREQ_W-1:0] dig_q;
  logic [DCNT_W-1:0] cnt_q;
  logic              busy_q, done_q;

  assign part = mcand_q * ACC_W'(dig_q[DIGIT_W-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && cnt_q == DCNT_W'(NDIG - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q   <= '0;
      mcand_q <= ACC_W'(pos_i);
      dig_q   <= freq_i;
      cnt_q   <= '0;
    end else if (busy_q) begin
      acc_q   <= acc_q + part;
      mcand_q <= mcand_q << DIGIT_W;
      dig_q   <= dig_q >> DIGIT_W;
      cnt_q   <= cnt_q + DCNT_W'(1);
    end
  end

  // round half up, wrap modulo one turn
  assign rnd     = acc_q + RND;
  assign phase_o = rnd[ACC_W-1 -: ANGLE_BITS];
  assign done_o  = done_q;

endmodule

// ----- hdl/sbd_cordic.sv -----
// iterative cordic rotation of one sample by minus the phase angle
module sbd_cordic (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic [sbd_pkg::ANGLE_BITS-1:0]        phase_i,
  input  logic signed [sbd_pkg::VAL_W-1:0]      value_i,
  output logic                                  done_o,
  output logic signed [sbd_pkg::VAL_W-1:0]      re_o,
  output logic signed [sbd_pkg::VAL_W-1:0]      im_o
);
  import sbd_pkg::*;

  logic [31:0]              ang, a_neg, a_f;
  logic                     flip;
  logic signed [XY_W-1:0]   vext, prod, z0;
  logic signed [XY_W-1:0]   x_q, y_q, z_q, dx, dy, at;
  logic [STEP_W-1:0]        step_q;
  logic                     busy_q, done_q;

  function automatic logic signed [VAL_W-1:0] rnd_sat(input logic signed [XY_W-1:0] v);
    logic signed [XY_W-1:0] t;
    logic signed [VAL_W-1:0] r;
    t = $signed(v + XY_W'(32768)) >>> 16;
    if (t > $signed(XY_W'(32767)))        r = 16'sh7fff;
    else if (t < -$signed(XY_W'(32768)))  r = 16'sh8000;
    else                                  r = t[VAL_W-1:0];
    return r;
  endfunction

  assign ang   = {phase_i, (32 - ANGLE_BITS)'(0)};
  assign a_neg = 32'd0 - ang;
  // second and third quadrant fold onto the right half plane
  assign flip  = ^a_neg[31:30];
  assign a_f   = flip ? a_neg + 32'h8000_0000 : a_neg;
  assign z0    = {{(XY_W-32){a_f[31]}}, a_f};
  assign vext  = {{(XY_W-VAL_W){value_i[VAL_W-1]}}, value_i};
  assign prod  = vext * GAIN_INV;

  assign dx = y_q >>> step_q;
  assign dy = x_q >>> step_q;
  assign at = $signed({{(XY_W-32){1'b0}}, atan_turns(step_q)});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && step_q == STEP_W'(CORDIC_STEPS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= flip ? -prod : prod;
      y_q    <= '0;
      z_q    <= z0;
      step_q <= '0;
    end else if (busy_q) begin
      if (!z_q[XY_W-1]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + at;
      end
      step_q <= step_q + STEP_W'(1);
    end
  end

  assign done_o = done_q;
  assign re_o   = rnd_sat(x_q);
  assign im_o   = rnd_sat(y_q);

endmodule

// ----- hdl/sbd_divider.sv -----
// two-lane restoring divider for the rounded mean of the sums
module sbd_divider (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [sbd_pkg::SUM_W-1:0]   sum_re_i,
  input  logic signed [sbd_pkg::SUM_W-1:0]   sum_im_i,
  input  logic [sbd_pkg::CNT_W-1:0]          count_i,
  output logic                               done_o,
  output logic signed [sbd_pkg::VAL_W-1:0]   mean_re_o,
  output logic signed [sbd_pkg::VAL_W-1:0]   mean_im_o
);
  import sbd_pkg::*;

  localparam int unsigned ITER_W = $clog2(DIV_W);

  logic signed [SUM_W-1:0] sum_in [2];
  logic [DIV_W-1:0]        n_start [2];
  logic [DIV_W-1:0]        n_q [2];
  logic [CNT_W-1:0]        rem_q [2];
  logic                    neg_q [2];
  logic signed [VAL_W-1:0] mean [2];
  logic [CNT_W-1:0]        c_q;
  logic [ITER_W-1:0]       it_q;
  logic                    busy_q, done_q;

  assign sum_in[0] = sum_re_i;
  assign sum_in[1] = sum_im_i;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      logic signed [DIV_W-1:0] se;
      logic [DIV_W-1:0]        mag;
      se = {sum_in[k][SUM_W-1], sum_in[k]};
      mag = se[DIV_W-1] ? DIV_W'(-se) : DIV_W'(se);
      n_start[k] = mag + DIV_W'(count_i >> 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && it_q == ITER_W'(DIV_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      c_q  <= count_i;
      it_q <= '0;
      for (int k = 0; k < 2; k++) begin
        n_q[k]   <= n_start[k];
        rem_q[k] <= '0;
        neg_q[k] <= sum_in[k][SUM_W-1];
      end
    end else if (busy_q) begin
      it_q <= it_q + ITER_W'(1);
      for (int k = 0; k < 2; k++) begin
        logic [CNT_W:0] trial;
        trial = {rem_q[k], n_q[k][DIV_W-1]};
        if (trial >= {1'b0, c_q}) begin
          rem_q[k] <= CNT_W'(trial - {1'b0, c_q});
          n_q[k]   <= {n_q[k][DIV_W-2:0], 1'b1};
        end else begin
          rem_q[k] <= trial[CNT_W-1:0];
          n_q[k]   <= {n_q[k][DIV_W-2:0], 1'b0};
        end
      end
    end
  end

  // quotient has replaced the dividend; restore sign and saturate
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      if (neg_q[k]) begin
        if (n_q[k] > DIV_W'(32768)) mean[k] = 16'sh8000;
        else                        mean[k] = VAL_W'(16'd0 - n_q[k][VAL_W-1:0]);
      end else begin
        if (n_q[k] > DIV_W'(32767)) mean[k] = 16'sh7fff;
        else                        mean[k] = n_q[k][VAL_W-1:0];
      end
    end
  end

  assign done_o    = done_q;
  assign mean_re_o = mean[0];
  assign mean_im_o = mean[1];

endmodule

// ----- hdl/single_bin_dft_correlator.sv -----
// single-bin dft correlator top level: control, running sums and output register
//
//  channel   signals                                  direction
//  cfg       cfg_we_i, cfg_wdata_i                    in  (frequency)
//  input     in_valid_i, in_stall_o, in_data_i        in  (one request per sample)
//  output    out_valid_o, out_stall_i, out_data_o     out (one result per sample)
//
// each sample passes through 6 multiplier digits, 16 cordic iterations and an accumulate step
// a last sample then also runs the 27-step restoring divider
// one sample is in flight at a time; a held result does not block the next request
// reset clears the sums, count, overflow flag, frequency and output valid
module single_bin_dft_correlator (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [sbd_pkg::FREQ_W-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  sbd_pkg::sbd_in_t          in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output sbd_pkg::sbd_out_t         out_data_o
);
  import sbd_pkg::*;

  sbd_state_e state_q, state_d;

  logic [FREQ_W-1:0]       freq_q;
  sbd_in_t                 item_q;
  logic signed [SUM_W-1:0] sum_re_q, sum_im_q, sum_re_d, sum_im_d;
  logic [CNT_W-1:0]        count_q;
  logic                    ovf_q, ovf_res_q;
  logic signed [VAL_W-1:0] rr_q, ri_q, wre_q, wim_q;
  logic                    out_valid_q;
  sbd_out_t                out_q;

  logic                    mul_start, mul_done, cor_start, cor_done;
  logic                    div_start, div_done, out_load, accept, cnt_full;
  logic [ANGLE_BITS-1:0]   phase;
  logic signed [VAL_W-1:0] cor_re, cor_im, div_re, div_im;

  sbd_phase_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .pos_i   (in_data_i.sample_position),
    .freq_i  (freq_q),
    .done_o  (mul_done),
    .phase_o (phase)
  );

  sbd_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .phase_i (phase),
    .value_i (item_q.sample_value),
    .done_o  (cor_done),
    .re_o    (cor_re),
    .im_o    (cor_im)
  );

  sbd_divider u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .sum_re_i  (sum_re_q),
    .sum_im_i  (sum_im_q),
    .count_i   (count_q),
    .done_o    (div_done),
    .mean_re_o (div_re),
    .mean_im_o (div_im)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (in_valid_i) state_d = ST_MUL;
      ST_MUL:       if (mul_done) state_d = ST_ROT;
      ST_ROT:       if (cor_done) state_d = ST_ACC;
      ST_ACC:       state_d = item_q.last_sample ? ST_DIV_START : ST_OUT;
      ST_DIV_START: state_d = ST_DIV;
      ST_DIV:       if (div_done) state_d = ST_OUT;
      ST_OUT:       if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    accept     = (state_q == ST_IDLE) && in_valid_i;
    mul_start  = accept;
    cor_start  = (state_q == ST_MUL) && mul_done;
    div_start  = (state_q == ST_DIV_START);
    out_load   = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);
  end

  assign cnt_full = (count_q >= CNT_W'(MAX_SAMPLES));

  // saturating sum update
  always_comb begin
    logic signed [SUM_W:0] sr, si;
    sr = {sum_re_q[SUM_W-1], sum_re_q} + {{(SUM_W+1-VAL_W){rr_q[VAL_W-1]}}, rr_q};
    si = {sum_im_q[SUM_W-1], sum_im_q} + {{(SUM_W+1-VAL_W){ri_q[VAL_W-1]}}, ri_q};
    if (sr[SUM_W] != sr[SUM_W-1]) sum_re_d = {sr[SUM_W], {(SUM_W-1){~sr[SUM_W]}}};
    else                          sum_re_d = sr[SUM_W-1:0];
    if (si[SUM_W] != si[SUM_W-1]) sum_im_d = {si[SUM_W], {(SUM_W-1){~si[SUM_W]}}};
    else                          sum_im_d = si[SUM_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      freq_q      <= '0;
      sum_re_q    <= '0;
      sum_im_q    <= '0;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) freq_q <= cfg_wdata_i;
      if (state_q == ST_ACC) begin
        if (cnt_full) begin
          ovf_q <= 1'b1;
        end else begin
          sum_re_q <= sum_re_d;
          sum_im_q <= sum_im_d;
          count_q  <= count_q + CNT_W'(1);
        end
      end
      if (state_q == ST_DIV && div_done) begin
        sum_re_q <= '0;
        sum_im_q <= '0;
        count_q  <= '0;
        ovf_q    <= 1'b0;
      end
      if (out_load)         out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) item_q <= in_data_i;
    if (state_q == ST_ROT && cor_done) begin
      rr_q <= cor_re;
      ri_q <= cor_im;
    end
    if (state_q == ST_ACC) begin
      ovf_res_q <= ovf_q | cnt_full;
      wre_q     <= '0;
      wim_q     <= '0;
    end
    if (state_q == ST_DIV && div_done) begin
      wre_q <= div_re;
      wim_q <= div_im;
    end
    if (out_load) begin
      out_q.rotated_real   <= rr_q;
      out_q.rotated_imag   <= ri_q;
      out_q.weight_real    <= wre_q;
      out_q.weight_imag    <= wim_q;
      out_q.weight_valid   <= item_q.last_sample;
      out_q.count_overflow <= ovf_res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_mul_done_in_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> state_q == ST_MUL)
    else $error("multiplier finished outside its state");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside its state");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_SAMPLES))
    else $error("sample count above limit");

  a_weight_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.weight_valid) |->
      (out_data_o.weight_real == 0 && out_data_o.weight_imag == 0))
    else $error("weight nonzero without weight valid");
`endif

endmodule

// ----- test/tb_top.sv -----
// testbench for the single-bin dft correlator: directed and random samples against a predictor
`timescale 1ns / 100ps

module tb_top;
  import sbd_pkg::*;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [FREQ_W-1:0] cfg_wdata_i;
  logic              in_valid_i;
  logic              in_stall_o;
  sbd_in_t           in_data_i;
  logic              out_valid_o;
  logic              out_stall_i;
  sbd_out_t          out_data_o;

  single_bin_dft_correlator DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // predictor state
  logic [FREQ_W-1:0] model_freq;
  longint            acc_re, acc_im;
  int unsigned       acc_count;
  bit                acc_ovf;

  sbd_out_t   pending_results[$];
  int         error_count;
  int unsigned send_idle_pct, recv_idle_pct;
  bit         recv_hold;

  localparam longint ATAN_TAB [CORDIC_STEPS] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861
  };
  localparam longint SUM_HI = 33554431;
  localparam longint SUM_LO = -33554432;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint clamp(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic longint set_mean(longint s, longint c);
    longint mag, q;
    if (c <= 0) return 0;
    mag = s < 0 ? -s : s;
    q = (mag + c / 2) / c;
    return clamp(s < 0 ? -q : q, -32768, 32767);
  endfunction

  // rotate one sample and update the running sums
  function automatic sbd_out_t correlate(sbd_in_t smp);
    sbd_out_t   r;
    longint     prod, phase, x, y, z, dx, dy, rr, ri;
    logic [31:0] ang, a;
    prod = longint'(smp.sample_position) * longint'(model_freq);
    phase = ((prod + (64'sd1 << (31 - ANGLE_BITS))) >>> (32 - ANGLE_BITS))
            & ((64'sd1 << ANGLE_BITS) - 1);
    ang = 32'(phase << (32 - ANGLE_BITS));
    a = 32'd0 - ang;
    x = longint'(smp.sample_value) * 39797;
    y = 0;
    if (a[31:30] == 2'd1 || a[31:30] == 2'd2) begin
      x = -x;
      a = a + 32'h8000_0000;
    end
    z = longint'(signed'(a));
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TAB[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TAB[i];
      end
    end
    rr = clamp((x + 32768) >>> 16, -32768, 32767);
    ri = clamp((y + 32768) >>> 16, -32768, 32767);
    if (acc_count >= MAX_SAMPLES) begin
      acc_ovf = 1'b1;
    end else begin
      acc_re = clamp(acc_re + rr, SUM_LO, SUM_HI);
      acc_im = clamp(acc_im + ri, SUM_LO, SUM_HI);
      acc_count++;
    end
    r = '0;
    r.rotated_real = 16'(rr);
    r.rotated_imag = 16'(ri);
    r.count_overflow = acc_ovf;
    if (smp.last_sample) begin
      r.weight_real = 16'(set_mean(acc_re, acc_count));
      r.weight_imag = 16'(set_mean(acc_im, acc_count));
      r.weight_valid = 1'b1;
      acc_re = 0; acc_im = 0; acc_count = 0; acc_ovf = 1'b0;
    end
    return r;
  endfunction

  task automatic send_sample(logic [23:0] pos, logic signed [15:0] val, bit last);
    sbd_in_t  smp;
    sbd_out_t exp_r;
    smp.sample_position = pos;
    smp.sample_value = val;
    smp.last_sample = last;
    // valid was dropped at the previous falling edge
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    in_data_i <= smp;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    exp_r = correlate(smp);
    pending_results = {pending_results, exp_r};
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  task automatic write_frequency(logic [23:0] f);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= f;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    model_freq = f;
  endtask

  // receiver: random stalls, or a long hold while recv_hold is set
  always @(negedge clk_i) begin
    if (rst_ni) out_stall_i <= recv_hold || ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    sbd_out_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding");
        error_count++;
      end else begin
        e = pending_results.pop_front();
        if (out_data_o.rotated_real !== e.rotated_real) begin
          $error("rotated_real exp %0d got %0d", e.rotated_real, out_data_o.rotated_real);
          error_count++;
        end
        if (out_data_o.rotated_imag !== e.rotated_imag) begin
          $error("rotated_imag exp %0d got %0d", e.rotated_imag, out_data_o.rotated_imag);
          error_count++;
        end
        if (out_data_o.weight_real !== e.weight_real) begin
          $error("weight_real exp %0d got %0d", e.weight_real, out_data_o.weight_real);
          error_count++;
        end
        if (out_data_o.weight_imag !== e.weight_imag) begin
          $error("weight_imag exp %0d got %0d", e.weight_imag, out_data_o.weight_imag);
          error_count++;
        end
        if (out_data_o.weight_valid !== e.weight_valid) begin
          $error("weight_valid exp %0b got %0b", e.weight_valid, out_data_o.weight_valid);
          error_count++;
        end
        if (out_data_o.count_overflow !== e.count_overflow) begin
          $error("count_overflow exp %0b got %0b", e.count_overflow,
                 out_data_o.count_overflow);
          error_count++;
        end
      end
    end
  end

  task automatic test_directed();
    logic signed [15:0] vals [6] = '{16'sh7fff, -16'sh8000, 16'sh0000, 16'sh4000,
                                     -16'sh0001, 16'sh1234};
    write_frequency(24'h100000);
    send_sample(24'h000000, vals[0], 1'b0);
    send_sample(24'h000400, vals[1], 1'b0);
    send_sample(24'h000800, vals[0], 1'b0);
    send_sample(24'h000c00, vals[1], 1'b1);
    // single sample set
    send_sample(24'h000200, vals[3], 1'b1);
    write_frequency(24'hffffff);
    for (int i = 0; i < 6; i++) send_sample(24'hffffff - 24'(i), vals[i], i == 5);
    write_frequency(24'h000000);
    send_sample(24'h123456, vals[0], 1'b0);
    send_sample(24'hfedcba, vals[0], 1'b1);
    write_frequency(24'h000001);
    send_sample(24'h000001, vals[4], 1'b0);
    send_sample(24'hffffff, vals[5], 1'b1);
    // zero mean
    write_frequency(24'h000000);
    for (int i = 0; i < 3; i++) send_sample(24'h0, vals[2], i == 2);
  endtask

  task automatic test_count_overflow();
    write_frequency(24'h000000);
    // fill past the sample limit with full-scale values
    for (int i = 0; i < MAX_SAMPLES + 4; i++)
      send_sample(24'($urandom), (i & 1) ? -16'sh8000 : 16'sh7fff, i == MAX_SAMPLES + 3);
  endtask

  task automatic random_sets(int n_items);
    int done;
    int len;
    done = 0;
    while (done < n_items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 1) : $urandom_range(8, 1);
      for (int i = 0; i < len; i++)
        send_sample(24'($urandom), 16'($urandom), i == len - 1);
      done += len;
    end
  endtask

  task automatic test_random();
    send_idle_pct = 23; recv_idle_pct = 51;
    write_frequency(24'($urandom));
    random_sets(260);
    send_idle_pct = 51; recv_idle_pct = 23;
    write_frequency(24'($urandom_range(255)));
    random_sets(260);
    send_idle_pct = 0; recv_idle_pct = 0;
    write_frequency(24'($urandom));
    random_sets(260);
  endtask

  task automatic test_backpressure();
    recv_hold = 1'b1;
    fork
      begin
        repeat (600) @(negedge clk_i);
        recv_hold = 1'b0;
      end
      random_sets(12);
    join
    // sender pauses until everything is back
    wait_drained();
    random_sets(20);
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    recv_hold = 1'b0;
    send_idle_pct = 0; recv_idle_pct = 0;
    error_count = 0;
    model_freq = '0;
    acc_re = 0; acc_im = 0; acc_count = 0; acc_ovf = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_count_overflow();
    test_backpressure();
    test_random();
    wait_drained();
    if (error_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
